>>> hdl/address_range_object_table_defines.svh
// Assertion macros for the address range object table.
`ifndef ADDRESS_RANGE_OBJECT_TABLE_DEFINES_SVH
`define ADDRESS_RANGE_OBJECT_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ARO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ARO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/aro_pkg.sv
package aro_pkg;

  localparam int FUNC_BITS   = 2;
  localparam int HANDLE_BITS = 16;
  localparam int ERR_BITS    = 2;

  localparam logic [FUNC_BITS-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_FIND   = 2'd2;

  localparam logic [ERR_BITS-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_PRESENT = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_ABSENT  = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_FULL    = 2'd3;

  // Control part of the token that walks the cell chain.
  typedef struct packed {
    logic                 active;     // token present in this stage
    logic [FUNC_BITS-1:0] func;
    logic                 commit;     // second pass of an add: write lowest free cell
    logic                 dup;        // add: base already held
    logic                 done;       // remove: entry cleared / commit: slot claimed
    logic                 best_valid; // find: a candidate base was seen
  } tok_ctl_t;

endpackage

>>> hdl/aro_cell.sv
module aro_cell #(
  parameter int ADDRESS_BITS = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  aro_pkg::tok_ctl_t              ctl_in,
  input  logic [ADDRESS_BITS-1:0]        addr_in,
  input  logic [ADDRESS_BITS-1:0]        len_in,
  input  logic [aro_pkg::HANDLE_BITS-1:0] hnd_in,
  input  logic [ADDRESS_BITS-1:0]        bbase_in,
  input  logic [ADDRESS_BITS-1:0]        blen_in,
  input  logic [aro_pkg::HANDLE_BITS-1:0] bhnd_in,
  output aro_pkg::tok_ctl_t              ctl_out,
  output logic [ADDRESS_BITS-1:0]        addr_out,
  output logic [ADDRESS_BITS-1:0]        len_out,
  output logic [aro_pkg::HANDLE_BITS-1:0] hnd_out,
  output logic [ADDRESS_BITS-1:0]        bbase_out,
  output logic [ADDRESS_BITS-1:0]        blen_out,
  output logic [aro_pkg::HANDLE_BITS-1:0] bhnd_out
);
  import aro_pkg::*;

  // Stored entry
  logic                    valid;
  logic [ADDRESS_BITS-1:0] base;
  logic [ADDRESS_BITS-1:0] length;
  logic [HANDLE_BITS-1:0]  handle;

  tok_ctl_t                ctl_next;
  logic [ADDRESS_BITS-1:0] bbase_next;
  logic [ADDRESS_BITS-1:0] blen_next;
  logic [HANDLE_BITS-1:0]  bhnd_next;
  logic                    base_match;
  logic                    wr_en;
  logic                    clr_en;

  assign base_match = valid && (base == addr_in);

  always_comb begin
    ctl_next   = ctl_in;
    bbase_next = bbase_in;
    blen_next  = blen_in;
    bhnd_next  = bhnd_in;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    if (ctl_in.active) begin
      case (ctl_in.func)
        FUNC_ADD: begin
          if (!ctl_in.commit) begin
            if (base_match) ctl_next.dup = 1'b1;
          end else if (!ctl_in.done && !valid) begin
            wr_en         = 1'b1;
            ctl_next.done = 1'b1;
          end
        end
        FUNC_REMOVE: begin
          if (base_match) begin
            clr_en        = 1'b1;
            ctl_next.done = 1'b1;
          end
        end
        FUNC_FIND: begin
          if (valid && (base <= addr_in) && (!ctl_in.best_valid || (base > bbase_in))) begin
            ctl_next.best_valid = 1'b1;
            bbase_next          = base;
            blen_next           = length;
            bhnd_next           = handle;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
      if (wr_en) valid <= 1'b1;
      else if (clr_en) valid <= 1'b0;
    end
    if (wr_en) begin
      base   <= addr_in;
      length <= len_in;
      handle <= hnd_in;
    end
    addr_out  <= addr_in;
    len_out   <= len_in;
    hnd_out   <= hnd_in;
    bbase_out <= bbase_next;
    blen_out  <= blen_next;
    bhnd_out  <= bhnd_next;
  end

endmodule

>>> hdl/address_range_object_table.sv
// An item walks the chain of entry cells as a token, one cell per cycle; an add
//   that inserts makes two passes (duplicate-check pass, then write pass).
// A new item is accepted only in the idle state, so the block takes no new item
//   until the previous one has been handed to the output register.
// Reset (rst, synchronous, high): table empty, count zero, no item in flight,
//   output register empty.
module address_range_object_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDRESS_BITS  = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [aro_pkg::FUNC_BITS-1:0]        func,
  input  logic [ADDRESS_BITS-1:0]              address,
  input  logic [ADDRESS_BITS-1:0]              region_length,
  input  logic [aro_pkg::HANDLE_BITS-1:0]      object_handle,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic [aro_pkg::HANDLE_BITS-1:0]      found_handle,
  output logic [aro_pkg::ERR_BITS-1:0]         error_code,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0]   entry_count
);
  import aro_pkg::*;

  `include "address_range_object_table_defines.svh"

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_PASS1, S_PASS2, S_FINISH} state_t;

  state_t state;

  // Request held for the whole operation
  logic [FUNC_BITS-1:0]    req_func;
  logic [ADDRESS_BITS-1:0] req_addr;
  logic [ADDRESS_BITS-1:0] req_len;
  logic [HANDLE_BITS-1:0]  req_hnd;
  logic                    launch;   // token enters cell 0 this cycle
  logic                    commit;   // token is the write pass of an add
  logic [CNT_W-1:0]        region_count;

  // Result staged before the output register
  logic                    res_hit;
  logic [HANDLE_BITS-1:0]  res_hnd;
  logic [ERR_BITS-1:0]     res_err;

  // Chain links: index k feeds cell k, index TABLE_ENTRIES is the tail
  tok_ctl_t                ctl_c   [TABLE_ENTRIES+1];
  logic [ADDRESS_BITS-1:0] addr_c  [TABLE_ENTRIES+1];
  logic [ADDRESS_BITS-1:0] len_c   [TABLE_ENTRIES+1];
  logic [HANDLE_BITS-1:0]  hnd_c   [TABLE_ENTRIES+1];
  logic [ADDRESS_BITS-1:0] bbase_c [TABLE_ENTRIES+1];
  logic [ADDRESS_BITS-1:0] blen_c  [TABLE_ENTRIES+1];
  logic [HANDLE_BITS-1:0]  bhnd_c  [TABLE_ENTRIES+1];

  tok_ctl_t                head_ctl; // fresh token for cell 0
  tok_ctl_t                tail;
  logic                    contained;

  // Head of the chain: fresh token built from the held request
  always_comb begin
    head_ctl        = '0;
    head_ctl.active = launch;
    head_ctl.func   = req_func;
    head_ctl.commit = commit;
  end
  assign ctl_c[0]   = head_ctl;
  assign addr_c[0]  = req_addr;
  assign len_c[0]   = req_len;
  assign hnd_c[0]   = req_hnd;
  assign bbase_c[0] = '0;
  assign blen_c[0]  = '0;
  assign bhnd_c[0]  = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    aro_cell #(
      .ADDRESS_BITS(ADDRESS_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl_c[g]),
      .addr_in  (addr_c[g]),
      .len_in   (len_c[g]),
      .hnd_in   (hnd_c[g]),
      .bbase_in (bbase_c[g]),
      .blen_in  (blen_c[g]),
      .bhnd_in  (bhnd_c[g]),
      .ctl_out  (ctl_c[g+1]),
      .addr_out (addr_c[g+1]),
      .len_out  (len_c[g+1]),
      .hnd_out  (hnd_c[g+1]),
      .bbase_out(bbase_c[g+1]),
      .blen_out (blen_c[g+1]),
      .bhnd_out (bhnd_c[g+1])
    );
  end

  assign tail = ctl_c[TABLE_ENTRIES];

  // Containment of the best candidate; exact, no wrap at the top of memory
  assign contained = tail.best_valid &&
                     ((req_addr - bbase_c[TABLE_ENTRIES]) < blen_c[TABLE_ENTRIES]);

  assign in_ready     = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launch       <= 1'b0;
      commit       <= 1'b0;
      out_valid    <= 1'b0;
      region_count <= '0;
    end else begin
      launch <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_func <= func;
            req_addr <= address;
            req_len  <= region_length;
            req_hnd  <= object_handle;
            launch   <= 1'b1;
            commit   <= 1'b0;
            state    <= S_PASS1;
          end
        end
        S_PASS1: begin
          if (tail.active) begin
            res_hit <= 1'b0;
            res_hnd <= '0;
            res_err <= ERR_OK;
            state   <= S_FINISH;
            case (req_func)
              FUNC_ADD: begin
                // duplicate beats full
                if (tail.dup) begin
                  res_err <= ERR_PRESENT;
                end else if (region_count == CNT_W'(TABLE_ENTRIES)) begin
                  res_err <= ERR_FULL;
                end else begin
                  launch <= 1'b1;
                  commit <= 1'b1;
                  state  <= S_PASS2;
                end
              end
              FUNC_REMOVE: begin
                if (tail.done) region_count <= region_count - CNT_W'(1);
                else res_err <= ERR_ABSENT;
              end
              FUNC_FIND: begin
                if (contained) begin
                  res_hit <= 1'b1;
                  res_hnd <= bhnd_c[TABLE_ENTRIES];
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PASS2: begin
          if (tail.active) begin
            region_count <= region_count + CNT_W'(1);
            state        <= S_FINISH;
          end
        end
        S_FINISH: begin
          // wait for the output register to drain; count is captured with the item
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            hit          <= res_hit;
            found_handle <= res_hnd;
            error_code   <= res_err;
            entry_count  <= region_count;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ARO_ASSERT_NOW(a_count_bound, 1'b1, region_count <= CNT_W'(TABLE_ENTRIES), "count over capacity")
  `ARO_ASSERT_NOW(a_tail_in_pass, tail.active, state == S_PASS1 || state == S_PASS2, "token out of pass")
  `ARO_ASSERT_NOW(a_hit_ok, out_valid && hit, error_code == ERR_OK, "hit with error")
  `ARO_ASSERT_NEXT(a_accept_launch, in_valid && in_ready, launch && state == S_PASS1, "no launch")

endmodule

>>> tb/tb_address_range_object_table.sv
module tb_address_range_object_table;
  import aro_pkg::*;

  localparam int ENTRIES    = 64;
  localparam int AW         = 48;
  localparam int COUNT_BITS = $clog2(ENTRIES + 1);
  localparam int RANDOM_ITEMS = 2000;
  // No progress for this many cycles means the block is hung.
  localparam int STALL_LIMIT  = 4000;
  // Longest item through the block (insert: two passes over the chain).
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [AW-1:0] ADDR_MAX  = {AW{1'b1}};
  localparam logic [AW-1:0] GRID_BASE = 48'h0000_7000_0000;

  typedef struct packed {
    logic                   hit;
    logic [HANDLE_BITS-1:0] handle;
    logic [ERR_BITS-1:0]    err;
    logic [COUNT_BITS-1:0]  count;
  } answer_t;

  // Shadow copy of the region table plus the answers still owed by the block.
  class region_tracker;
    bit                   used      [ENTRIES];
    bit [AW-1:0]          base_of   [ENTRIES];
    bit [AW-1:0]          len_of    [ENTRIES];
    bit [HANDLE_BITS-1:0] handle_of [ENTRIES];
    int unsigned          held;
    answer_t              answers_due[$];
    int unsigned          mismatches;

    function int slot_with_base(logic [AW-1:0] a);
      for (int i = 0; i < ENTRIES; i++)
        if (used[i] && base_of[i] == a) return i;
      return -1;
    endfunction

    // Random occupied slot, -1 when the table is empty.
    function int pick_used();
      int idx[$];
      for (int i = 0; i < ENTRIES; i++)
        if (used[i]) idx.push_back(i);
      if (idx.size() == 0) return -1;
      return idx[$urandom_range(0, idx.size() - 1)];
    endfunction

    function void note_request(logic [FUNC_BITS-1:0] f, logic [AW-1:0] a,
                               logic [AW-1:0] l, logic [HANDLE_BITS-1:0] h);
      answer_t ans;
      int      slot;
      int      best;
      ans  = '0;
      slot = -1;
      best = -1;
      case (f)
        FUNC_ADD: begin
          // duplicate check wins over full
          if (slot_with_base(a) >= 0) ans.err = ERR_PRESENT;
          else begin
            for (int i = 0; i < ENTRIES; i++)
              if (!used[i] && slot < 0) slot = i;
            if (slot < 0) ans.err = ERR_FULL;
            else begin
              used[slot]      = 1'b1;
              base_of[slot]   = a;
              len_of[slot]    = l;
              handle_of[slot] = h;
              held++;
            end
          end
        end
        FUNC_REMOVE: begin
          slot = slot_with_base(a);
          if (slot < 0) ans.err = ERR_ABSENT;
          else begin
            used[slot] = 1'b0;
            held--;
          end
        end
        FUNC_FIND: begin
          for (int i = 0; i < ENTRIES; i++)
            if (used[i] && base_of[i] <= a && (best < 0 || base_of[i] > base_of[best]))
              best = i;
          // base <= a, so the difference cannot wrap
          if (best >= 0 && (a - base_of[best]) < len_of[best]) begin
            ans.hit    = 1'b1;
            ans.handle = handle_of[best];
          end
        end
        default: ;
      endcase
      ans.count = held[COUNT_BITS-1:0];
      answers_due.push_back(ans);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0d handle=%h err=%0d count=%0d",
                   got.hit, got.handle, got.err, got.count);
        return;
      end
      want = answers_due.pop_front();
      if (got.hit !== want.hit || got.handle !== want.handle ||
          got.err !== want.err || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want hit=%0d handle=%h err=%0d count=%0d, got hit=%0d handle=%h err=%0d count=%0d",
                   want.hit, want.handle, want.err, want.count,
                   got.hit, got.handle, got.err, got.count);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [FUNC_BITS-1:0]   func = FUNC_FIND;
  logic [AW-1:0]          address = '0;
  logic [AW-1:0]          region_length = '0;
  logic [HANDLE_BITS-1:0] object_handle = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   hit;
  logic [HANDLE_BITS-1:0] found_handle;
  logic [ERR_BITS-1:0]    error_code;
  logic [COUNT_BITS-1:0]  entry_count;

  region_tracker tracker = new;
  int unsigned   idle_cycles = 0;
  int unsigned   burst_left = 0;

  address_range_object_table #(
    .TABLE_ENTRIES(ENTRIES),
    .ADDRESS_BITS (AW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .address      (address),
    .region_length(region_length),
    .object_handle(object_handle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .found_handle (found_handle),
    .error_code   (error_code),
    .entry_count  (entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Present one item, hold it until taken, then maybe close the burst with a gap.
  task automatic send_item(logic [FUNC_BITS-1:0] f, logic [AW-1:0] a,
                           logic [AW-1:0] l, logic [HANDLE_BITS-1:0] h);
    int unsigned gap;
    int unsigned pick;
    func          <= f;
    address       <= a;
    region_length <= l;
    object_handle <= h;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(f, a, l, h);
    if (burst_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = $urandom_range(1, 4);
      else if (pick < 90) gap = $urandom_range(5, 80);
      else gap = $urandom_range(81, 200);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 70) burst_left = $urandom_range(0, 3);
      else if (pick < 95) burst_left = $urandom_range(4, 19);
      else burst_left = $urandom_range(40, 80);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [AW-1:0] any_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[AW-1:0];
  endfunction

  // Bases near each other so regions overlap and finds land inside them.
  function automatic logic [AW-1:0] grid_addr();
    return GRID_BASE + AW'($urandom_range(0, 127)) * AW'('h1000);
  endfunction

  function automatic logic [AW-1:0] any_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return '0;
    if (pick < 30) return any_addr();
    return AW'($urandom_range(1, 'h3000));
  endfunction

  function automatic logic [AW-1:0] base_choice(int unsigned reuse_pct);
    int slot;
    int unsigned pick;
    slot = tracker.pick_used();
    pick = $urandom_range(0, 99);
    if (slot >= 0 && pick < reuse_pct) return tracker.base_of[slot];
    if (pick % 3 == 0) return any_addr();
    return grid_addr();
  endfunction

  function automatic logic [AW-1:0] find_addr();
    int slot;
    int unsigned pick;
    logic [AW-1:0] span;
    slot = tracker.pick_used();
    pick = $urandom_range(0, 99);
    if (slot >= 0 && pick < 60) begin
      span = (tracker.len_of[slot] < 'h4000) ? tracker.len_of[slot] + 8 : AW'('h4000);
      return tracker.base_of[slot] + AW'($urandom_range(0, int'(span)));
    end
    if (slot >= 0 && pick < 66) return tracker.base_of[slot] - 1;
    if (pick < 85) return grid_addr() + AW'($urandom_range(0, 'hFFF));
    return any_addr();
  endfunction

  // Receiver: ready mode and pattern are redrawn at regular intervals; sometimes always ready.
  int unsigned     stall_mode = 0;
  int unsigned     stall_phase = 0;
  logic [15:0]     stall_pattern = 16'hFFFF;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_answer('{hit, found_handle, error_code, entry_count});
    stall_phase <= stall_phase + 1;
    if (stall_phase % 300 == 0) begin
      stall_mode    <= $urandom_range(0, 2);
      stall_pattern <= 16'($urandom()) | 16'h0001;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= stall_pattern[stall_phase % 16];
    endcase
  end

  // Watchdog on forward progress of either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned mode;
    logic [FUNC_BITS-1:0] f;
    logic [AW-1:0] a;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, bad ops, zero length, top of space, nesting.
    send_item(FUNC_FIND,   '0,            '0,       16'h0000);
    send_item(FUNC_REMOVE, 48'h1000,      '0,       16'h0000);
    send_item(FUNC_UNUSED, ADDR_MAX,      ADDR_MAX, 16'hFFFF);
    send_item(FUNC_ADD,    '0,            '0,       16'h0000);
    send_item(FUNC_FIND,   '0,            '0,       16'h0000);
    send_item(FUNC_ADD,    '0,            48'h10,   16'h1111);
    send_item(FUNC_ADD,    ADDR_MAX,      ADDR_MAX, 16'hFFFF);
    send_item(FUNC_FIND,   ADDR_MAX,      '0,       16'h0000);
    send_item(FUNC_ADD,    48'h1000,      48'h100,  16'h1234);
    send_item(FUNC_FIND,   48'h1000,      '0,       16'h0000);
    send_item(FUNC_FIND,   48'h10FF,      '0,       16'h0000);
    send_item(FUNC_FIND,   48'h1100,      '0,       16'h0000);
    send_item(FUNC_FIND,   48'h0FFF,      '0,       16'h0000);
    send_item(FUNC_ADD,    48'h1080,      48'h1000, 16'hABCD);
    send_item(FUNC_FIND,   48'h1090,      '0,       16'h0000);
    send_item(FUNC_REMOVE, 48'h1080,      ADDR_MAX, 16'hFFFF);
    send_item(FUNC_FIND,   48'h1090,      '0,       16'h0000);
    send_item(FUNC_REMOVE, 48'h1080,      '0,       16'h0000);
    send_item(FUNC_ADD,    ADDR_MAX - 1,  48'h1,    16'h0005);
    send_item(FUNC_FIND,   ADDR_MAX - 1,  '0,       16'h0000);
    send_item(FUNC_REMOVE, ADDR_MAX,      '0,       16'h0000);
    send_item(FUNC_REMOVE, ADDR_MAX - 1,  '0,       16'h0000);
    send_item(FUNC_REMOVE, 48'h1000,      '0,       16'h0000);
    send_item(FUNC_REMOVE, '0,            '0,       16'h0000);

    // Random: phases that fill the table past full, mix, then drain it.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mode = (n / 250) % 3;
      pick = $urandom_range(0, 99);
      if (pick < 3) f = FUNC_UNUSED;
      else if (mode == 0) f = (pick < 73) ? FUNC_ADD : (pick < 83) ? FUNC_REMOVE : FUNC_FIND;
      else if (mode == 1) f = (pick < 38) ? FUNC_ADD : (pick < 63) ? FUNC_REMOVE : FUNC_FIND;
      else f = (pick < 13) ? FUNC_ADD : (pick < 68) ? FUNC_REMOVE : FUNC_FIND;
      case (f)
        FUNC_ADD:    a = base_choice(20);
        FUNC_REMOVE: a = base_choice(80);
        FUNC_FIND:   a = find_addr();
        default:     a = any_addr();
      endcase
      send_item(f, a, any_length(), 16'($urandom()));
    end
    in_valid <= 1'b0;

    while (tracker.answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/aro_pkg.sv
hdl/aro_cell.sv
hdl/address_range_object_table.sv
tb/tb_address_range_object_table.sv
